// ----- hw/rtl/packet_rate_shaper_window_drop_assert.svh -----
// Assertion macros for the packet rate shaper.
// Depends on clk and rst_n being visible in the module that expands them.
`ifndef PACKET_RATE_SHAPER_WINDOW_DROP_ASSERT_SVH
`define PACKET_RATE_SHAPER_WINDOW_DROP_ASSERT_SVH

// Check that cons holds whenever ante holds, outside reset.
`define PRS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shaper assertion failed");

// Check that cond holds at every clock edge, outside reset.
`define PRS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("shaper invariant failed");

`endif

// ----- hw/rtl/prs_pkg.sv -----
// Shared types and constants for the packet rate shaper.
// No dependencies.
package prs_pkg;

    localparam int LEN_W   = 16;
    localparam int TIME_W  = 48;
    localparam int RATE_W  = 40;
    localparam int WIN_W   = 17;
    localparam int MB_W    = 14;
    localparam int LIMIT_W = 34;
    localparam int DELAY_W = 32;
    localparam int PROD_W  = TIME_W + RATE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [WIN_W-1:0] WINDOW       = 17'd100000;
    localparam logic [19:0]      BYTES_PER_MB = 20'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT_MB = 2'd0,
        CFG_SHAPE_INBOUND  = 2'd1,
        CFG_SHAPE_OUTBOUND = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  packet_len;
        logic              is_outbound;
        logic [TIME_W-1:0] now_ms;
    } pkt_t;

    typedef struct packed {
        logic               handled;
        logic               drop;
        logic [DELAY_W-1:0] delay_ms;
    } res_t;

endpackage

// ----- hw/rtl/packet_rate_shaper_window_drop.sv -----
// Top level of the fixed-window packet rate shaper.
// Depends on prs_pkg, prs_mul, prs_div and the assertion macro header.
//
// Channels: pkt (valid/ready) carries one packet event per transfer; res
// (valid/ready) returns exactly one result per packet, in order; cfg
// (valid/ready, always ready) writes speed_limit_mb, shape_inbound and
// shape_outbound by index. The user must write them only while the block
// is idle; the block itself does not enforce this.
// A packet passes idle, update, check (shaped direction only), then done;
// over a nonzero limit, a hold delay is computed between check and done by
// the 40-step shift-add multiplier and the 32-step restoring divider, one
// bit per cycle each. The divider skips its steps when the delay saturates.
// One packet is in flight at a time; pkt_ready is high in the idle state,
// entered the cycle after a result is loaded.
// The result sits in an output register, so a new packet is taken while
// res waits; if the receiver still stalls when the next result is ready,
// the block holds that result and takes no packet until res transfers.
// Reset clears the byte count, window count and last time, and sets the
// speed limit to 1 MB with both directions shaped.
`include "packet_rate_shaper_window_drop_assert.svh"

module packet_rate_shaper_window_drop
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pkt_valid,
    output logic                              pkt_ready,
    input  prs_pkg::pkt_t                     pkt,
    output logic                              res_valid,
    input  logic                              res_ready,
    output prs_pkg::res_t                     res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prs_pkg::MB_W-1:0]          cfg_data
);

    prs_pkg::state_t state_reg;
    prs_pkg::state_t state_next;

    logic [prs_pkg::MB_W-1:0]    speed_limit_mb_reg;
    logic                        shape_inbound_reg;
    logic                        shape_outbound_reg;

    logic [prs_pkg::RATE_W-1:0]  rate_reg;
    logic [prs_pkg::WIN_W-1:0]   window_reg;
    logic [prs_pkg::TIME_W-1:0]  last_reg;

    logic [prs_pkg::LEN_W-1:0]   len_reg;
    logic                        outb_reg;
    logic [prs_pkg::TIME_W-1:0]  now_reg;
    logic [prs_pkg::TIME_W-1:0]  gap_reg;
    logic [prs_pkg::LIMIT_W-1:0] limit_reg;
    logic                        handled_reg;
    logic                        drop_reg;
    logic [prs_pkg::DELAY_W-1:0] delay_reg;

    prs_pkg::res_t               res_reg;
    logic                        res_valid_reg;

    logic                        enabled;
    logic [prs_pkg::RATE_W:0]    rate_sum;
    logic [prs_pkg::RATE_W-1:0]  rate_sat;
    logic                        win_reset;
    logic [prs_pkg::WIN_W:0]     win_sum;
    logic [prs_pkg::WIN_W-1:0]   win_base;
    logic                        over_limit;
    logic                        limit_zero;
    logic                        mul_start;
    logic                        mul_done;
    logic [prs_pkg::PROD_W-1:0]  product;
    logic                        div_start;
    logic                        div_done;
    logic [prs_pkg::DELAY_W-1:0] quotient;
    logic                        res_load;
    logic                        pkt_xfer;

    always_comb
    begin
        enabled   = outb_reg ? shape_outbound_reg : shape_inbound_reg;
        rate_sum  = {1'b0, rate_reg} + (prs_pkg::RATE_W + 1)'(len_reg);
        rate_sat  = rate_sum[prs_pkg::RATE_W] ? '1 : rate_sum[prs_pkg::RATE_W-1:0];
        win_reset = {1'b0, now_reg}
                  > ({1'b0, last_reg} + (prs_pkg::TIME_W + 1)'(prs_pkg::WINDOW));
        win_base  = win_reset ? '0 : window_reg;
        win_sum   = {1'b0, win_base} + (prs_pkg::WIN_W + 1)'(len_reg);
        over_limit = rate_reg > prs_pkg::RATE_W'(limit_reg);
        limit_zero = limit_reg == '0;
        pkt_xfer   = pkt_valid && pkt_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prs_pkg::S_IDLE:
            begin
                if (pkt_valid)
                begin
                    state_next = prs_pkg::S_UPDATE;
                end
            end
            prs_pkg::S_UPDATE:
            begin
                state_next = enabled ? prs_pkg::S_CHECK : prs_pkg::S_DONE;
            end
            prs_pkg::S_CHECK:
            begin
                state_next = (over_limit && !limit_zero) ? prs_pkg::S_MUL : prs_pkg::S_DONE;
            end
            prs_pkg::S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = prs_pkg::S_DIV;
                end
            end
            prs_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = prs_pkg::S_DONE;
                end
            end
            prs_pkg::S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = prs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = prs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pkt_ready = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        res_load  = 1'b0;
        unique case (state_reg)
            prs_pkg::S_IDLE:   pkt_ready = 1'b1;
            prs_pkg::S_CHECK:  mul_start = over_limit && !limit_zero;
            prs_pkg::S_MUL:    div_start = mul_done;
            prs_pkg::S_DONE:   res_load  = !res_valid_reg || res_ready;
            default:           pkt_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= prs_pkg::S_IDLE;
            speed_limit_mb_reg <= prs_pkg::MB_W'(1);
            shape_inbound_reg  <= 1'b1;
            shape_outbound_reg <= 1'b1;
            rate_reg           <= '0;
            window_reg         <= '0;
            last_reg           <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (prs_pkg::cfg_idx_t'(cfg_index))
                    prs_pkg::CFG_SPEED_LIMIT_MB: speed_limit_mb_reg <= cfg_data;
                    prs_pkg::CFG_SHAPE_INBOUND:  shape_inbound_reg  <= cfg_data[0];
                    prs_pkg::CFG_SHAPE_OUTBOUND: shape_outbound_reg <= cfg_data[0];
                    default:                     speed_limit_mb_reg <= speed_limit_mb_reg;
                endcase
            end
            if (state_reg == prs_pkg::S_UPDATE && enabled)
            begin
                rate_reg <= win_reset ? '0 : rate_sat;
                if (win_sum <= (prs_pkg::WIN_W + 1)'(prs_pkg::WINDOW))
                begin
                    window_reg <= win_sum[prs_pkg::WIN_W-1:0];
                end
                else
                begin
                    window_reg <= win_base;
                end
                last_reg <= now_reg;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_xfer)
        begin
            len_reg  <= pkt.packet_len;
            outb_reg <= pkt.is_outbound;
            now_reg  <= pkt.now_ms;
        end
        if (state_reg == prs_pkg::S_UPDATE)
        begin
            handled_reg <= enabled;
            drop_reg    <= enabled
                        && (win_sum > (prs_pkg::WIN_W + 1)'(prs_pkg::WINDOW));
            delay_reg   <= '0;
            gap_reg     <= now_reg - last_reg;
            limit_reg   <= {{(prs_pkg::LIMIT_W - prs_pkg::MB_W){1'b0}}, speed_limit_mb_reg}
                         * {{(prs_pkg::LIMIT_W - 20){1'b0}}, prs_pkg::BYTES_PER_MB};
        end
        if (state_reg == prs_pkg::S_CHECK && over_limit && limit_zero)
        begin
            delay_reg <= '1;
        end
        if (div_done)
        begin
            delay_reg <= quotient;
        end
        if (res_load)
        begin
            res_reg.handled  <= handled_reg;
            res_reg.drop     <= drop_reg;
            res_reg.delay_ms <= delay_reg;
        end
    end

    prs_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (gap_reg),
        .multiplier   (rate_reg - prs_pkg::RATE_W'(limit_reg)),
        .done         (mul_done),
        .product      (product)
    );

    prs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (limit_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `PRS_ASSERT_ALWAYS(a_window_bound, window_reg <= prs_pkg::WINDOW)
    `PRS_ASSERT_IMPLY(a_mul_over_limit, mul_start, over_limit && !limit_zero && enabled)
    `PRS_ASSERT_IMPLY(a_unhandled_clean, res_valid_reg && !res_reg.handled,
        !res_reg.drop && res_reg.delay_ms == '0)
    `PRS_ASSERT_IMPLY(a_pkt_idle_only, pkt_xfer, state_reg == prs_pkg::S_IDLE && !mul_done)

endmodule

// ----- hw/rtl/prs_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on prs_pkg.
module prs_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [prs_pkg::TIME_W-1:0]    multiplicand,
    input  logic [prs_pkg::RATE_W-1:0]    multiplier,
    output logic                          done,
    output logic [prs_pkg::PROD_W-1:0]    product
);

    localparam int CNT_W = $clog2(prs_pkg::RATE_W);

    logic [prs_pkg::PROD_W-1:0] prod_reg;
    logic [prs_pkg::TIME_W-1:0] mcand_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [prs_pkg::TIME_W:0]   sum;
    logic                       last_step;

    always_comb
    begin
        sum = {1'b0, prod_reg[prs_pkg::PROD_W-1:prs_pkg::RATE_W]}
            + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        last_step = cnt_reg == CNT_W'(prs_pkg::RATE_W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= multiplicand;
            prod_reg  <= {{prs_pkg::TIME_W{1'b0}}, multiplier};
        end
        else if (busy_reg)
        begin
            // shift right, folding in the partial sum
            prod_reg <= {sum, prod_reg[prs_pkg::RATE_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ----- hw/rtl/prs_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on prs_pkg.
module prs_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [prs_pkg::PROD_W-1:0]    dividend,
    input  logic [prs_pkg::LIMIT_W-1:0]   divisor,
    output logic                          done,
    output logic [prs_pkg::DELAY_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(prs_pkg::DELAY_W);
    localparam int HI_W  = prs_pkg::PROD_W - prs_pkg::DELAY_W;

    logic [prs_pkg::LIMIT_W-1:0] rem_reg;
    logic [prs_pkg::LIMIT_W-1:0] div_reg;
    logic [prs_pkg::DELAY_W-1:0] q_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        sat;
    logic                        last_step;
    logic [prs_pkg::LIMIT_W+1:0] trial;

    always_comb
    begin
        sat   = dividend[prs_pkg::PROD_W-1:prs_pkg::DELAY_W] >= HI_W'(divisor);
        trial = {1'b0, rem_reg, q_reg[prs_pkg::DELAY_W-1]} - {2'b00, div_reg};
        last_step = cnt_reg == CNT_W'(prs_pkg::DELAY_W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= start ? sat : (busy_reg && last_step);
            if (start)
            begin
                busy_reg <= !sat;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= dividend[prs_pkg::DELAY_W +: prs_pkg::LIMIT_W];
            q_reg   <= sat ? '1 : dividend[prs_pkg::DELAY_W-1:0];
        end
        else if (busy_reg)
        begin
            if (!trial[prs_pkg::LIMIT_W+1])
            begin
                rem_reg <= trial[prs_pkg::LIMIT_W-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[prs_pkg::LIMIT_W-2:0], q_reg[prs_pkg::DELAY_W-1]};
            end
            q_reg <= {q_reg[prs_pkg::DELAY_W-2:0], !trial[prs_pkg::LIMIT_W+1]};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
